FILE: rtl/fmfr_pkg.sv
// Shared types, constants and helpers of the first-match find-and-replace core.
// Used by fmfr_csr, fmfr_match and first_match_find_replace_core; no dependencies.
`timescale 1ns / 1ps

package fmfr_pkg;

   // Longest pattern that the window can hold.
   localparam int MaxPatternLen = 8;
   localparam int WinDepth      = 8;
   localparam int ByteW         = 8;
   localparam int FillW         = 4;
   localparam int TextW         = 64;
   localparam int LenW          = 4;
   localparam int CsrIndexW     = 2;

   localparam logic [ByteW-1:0] SpaceByte = 8'h20;
   localparam logic [ByteW-1:0] ZeroByte  = 8'h00;

   // Item kinds on the request stream.
   localparam logic KindText  = 1'b0;
   localparam logic KindFlush = 1'b1;

   // Configuration register indexes.
   localparam logic [CsrIndexW-1:0] CsrFindText    = 2'd0;
   localparam logic [CsrIndexW-1:0] CsrFindLength  = 2'd1;
   localparam logic [CsrIndexW-1:0] CsrReplaceText = 2'd2;
   localparam logic [CsrIndexW-1:0] CsrReplaceLen  = 2'd3;

   typedef logic [WinDepth-1:0][ByteW-1:0] window_type;

   // Configuration as seen by the datapath, lengths already clamped.
   typedef struct packed {
      logic [TextW-1:0] find_text;
      logic [LenW-1:0]  find_len;
      logic [TextW-1:0] replace_text;
      logic [LenW-1:0]  replace_len;
   } cfg_type;

   // Window after the new byte is appended and any replacement applied.
   typedef struct packed {
      window_type       window;
      logic [FillW-1:0] fill;
      logic             hit;
   } match_type;

   function automatic logic [LenW-1:0] clamp_len(input logic [LenW-1:0] len, input int limit);
      logic [LenW-1:0] lim;
      lim = LenW'(limit);
      clamp_len = (len > lim) ? lim : len;
   endfunction

endpackage

FILE: rtl/fmfr_csr.sv
// Configuration registers of the find-and-replace core.
// Depends on fmfr_pkg for register indexes and the cfg_type struct.
`timescale 1ns / 1ps

module fmfr_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [fmfr_pkg::CsrIndexW-1:0]     csr_index,
   input  logic [fmfr_pkg::TextW-1:0]         csr_data,
   output fmfr_pkg::cfg_type                  cfg
);

   logic [fmfr_pkg::TextW-1:0] find_text_ff;
   logic [fmfr_pkg::LenW-1:0]  find_len_ff;
   logic [fmfr_pkg::TextW-1:0] repl_text_ff;
   logic [fmfr_pkg::LenW-1:0]  repl_len_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         find_text_ff <= '0;
         find_len_ff  <= '0;
         repl_text_ff <= '0;
         repl_len_ff  <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            fmfr_pkg::CsrFindText:    find_text_ff <= csr_data;
            fmfr_pkg::CsrFindLength:  find_len_ff  <= csr_data[fmfr_pkg::LenW-1:0];
            fmfr_pkg::CsrReplaceText: repl_text_ff <= csr_data;
            fmfr_pkg::CsrReplaceLen:  repl_len_ff  <= csr_data[fmfr_pkg::LenW-1:0];
         endcase
      end
   end

   always_comb begin
      cfg.find_text    = find_text_ff;
      cfg.find_len     = fmfr_pkg::clamp_len(find_len_ff, fmfr_pkg::MaxPatternLen);
      cfg.replace_text = repl_text_ff;
      cfg.replace_len  = fmfr_pkg::clamp_len(repl_len_ff, fmfr_pkg::WinDepth);
   end

endmodule

FILE: rtl/fmfr_match.sv
// Append, compare and overwrite logic of the find-and-replace window.
// Depends on fmfr_pkg for window_type, cfg_type and match_type.
`timescale 1ns / 1ps

module fmfr_match (
   input  fmfr_pkg::window_type             window,
   input  logic [fmfr_pkg::FillW-1:0]       fill,
   input  logic                             replaced,
   input  logic [fmfr_pkg::ByteW-1:0]       in_byte,
   input  fmfr_pkg::cfg_type                cfg,
   output fmfr_pkg::match_type              result
);

   fmfr_pkg::window_type       app;
   fmfr_pkg::window_type       find_b;
   fmfr_pkg::window_type       repl_b;
   fmfr_pkg::window_type       win_out;
   logic [fmfr_pkg::FillW-1:0] fill_app;
   logic [fmfr_pkg::FillW-1:0] base;
   logic [fmfr_pkg::WinDepth-1:0] lane_eq;
   logic                       enable;
   logic                       hit;

   assign find_b = cfg.find_text;
   assign repl_b = cfg.replace_text;

   // Append the new byte behind the youngest held byte.
   always_comb begin
      for (int p = 0; p < fmfr_pkg::WinDepth; p++) begin
         app[p] = (fill < fmfr_pkg::FillW'(fmfr_pkg::WinDepth) &&
                   fill == fmfr_pkg::FillW'(p)) ? in_byte : window[p];
      end
      fill_app = (fill < fmfr_pkg::FillW'(fmfr_pkg::WinDepth)) ?
                 fill + fmfr_pkg::FillW'(1) : fill;
   end

   assign enable = (cfg.find_len != '0) && !replaced && (fill_app >= cfg.find_len);
   assign base   = fill_app - cfg.find_len;

   // Compare the youngest find_len bytes with the pattern, one lane per pattern byte.
   always_comb begin
      logic [2:0] idx;
      idx = '0;
      for (int i = 0; i < fmfr_pkg::WinDepth; i++) begin
         idx        = base[2:0] + 3'(i);
         lane_eq[i] = (fmfr_pkg::FillW'(i) >= cfg.find_len) || (app[idx] == find_b[i]);
      end
   end

   assign hit = enable && (&lane_eq);

   // On a hit the matched span takes replacement bytes, then spaces.
   always_comb begin
      logic [2:0] off;
      logic       in_span;
      off     = '0;
      in_span = 1'b0;
      for (int p = 0; p < fmfr_pkg::WinDepth; p++) begin
         off     = 3'(p) - base[2:0];
         in_span = (fmfr_pkg::FillW'(p) >= base) && (fmfr_pkg::FillW'(p) < fill_app);
         if (hit && in_span) begin
            win_out[p] = ({1'b0, off} < cfg.replace_len) ? repl_b[off] :
                         fmfr_pkg::SpaceByte;
         end else begin
            win_out[p] = app[p];
         end
      end
   end

   assign result = '{window: win_out, fill: fill_app, hit: hit};

endmodule

FILE: rtl/first_match_find_replace_core.sv
// Top level of the streaming first-match find-and-replace core.
// Depends on fmfr_pkg, fmfr_csr and fmfr_match.
`timescale 1ns / 1ps

//  Channel | Direction | Handshake            | Payload
//  --------+-----------+----------------------+-------------------------------------------
//  req     | in        | req_tvalid/tready    | tdata: in_byte; tuser: kind (1 = flush)
//  rsp     | out       | rsp_tvalid/tready    | tdata: out_byte; tuser: byte_valid;
//          |           |                      | tlast: end_of_text
//  csr     | in        | csr_valid/csr_ready  | csr_index, csr_data (always ready)
//
// A text byte is appended, compared and, where it pushes the oldest byte out of the window,
// that byte is registered onto rsp in the same cycle, so one beat per cycle is sustained
// while rsp is not stalled. A flush with n bytes held gives n beats (one byteless beat if the
// window is empty); after the pattern is shortened the surplus bytes leave one per cycle
// while rsp is not stalled. All beats pass the single result register; requests are held off
// while such a drain runs or a result waits on a stalled rsp. Reset is synchronous and active
// high; it clears the fill count, the replaced flag, the drain state and rsp_tvalid.

module first_match_find_replace_core (
   input  logic                           clock,
   input  logic                           reset,
   // Request stream.
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [7:0]                     req_tdata,   // [7:0] in_byte
   input  logic                           req_tuser,   // [0] kind
   // Result stream.
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [7:0]                     rsp_tdata,   // [7:0] out_byte
   output logic                           rsp_tuser,   // [0] byte_valid
   output logic                           rsp_tlast,
   // Configuration write channel.
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [fmfr_pkg::CsrIndexW-1:0] csr_index,
   input  logic [fmfr_pkg::TextW-1:0]     csr_data
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DRAIN_TEXT,
      ST_DRAIN_FLUSH
   } state_type;

   fmfr_pkg::cfg_type          cfg;
   fmfr_pkg::match_type        mres;

   state_type                  state_ff, state_in;
   fmfr_pkg::window_type       win_ff, win_in;
   logic [fmfr_pkg::FillW-1:0] fill_ff, fill_in;
   logic                       repl_ff, repl_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [fmfr_pkg::ByteW-1:0] rsp_byte_ff, rsp_byte_in;
   logic                       rsp_flag_ff, rsp_flag_in;
   logic                       rsp_last_ff, rsp_last_in;

   logic                       out_free;
   logic                       req_accept;
   logic                       emit;
   logic [fmfr_pkg::FillW-1:0] depth;
   logic [fmfr_pkg::FillW-1:0] fill_dec;
   logic [fmfr_pkg::FillW-1:0] mfill_dec;
   fmfr_pkg::window_type       shifted;
   fmfr_pkg::window_type       mshifted;

   fmfr_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   fmfr_match u_match (
      .window   (win_ff),
      .fill     (fill_ff),
      .replaced (repl_ff),
      .in_byte  (req_tdata),
      .cfg      (cfg),
      .result   (mres)
   );

   // The result register is free when empty or being taken in this cycle.
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE) && out_free;
   assign req_accept = req_tvalid && req_tready;

   // With matching disabled the window is one byte deep, so bytes pass straight through.
   assign depth     = (cfg.find_len == '0) ? fmfr_pkg::FillW'(1) : cfg.find_len;
   assign fill_dec  = fill_ff - fmfr_pkg::FillW'(1);
   assign mfill_dec = mres.fill - fmfr_pkg::FillW'(1);
   assign shifted   = {fmfr_pkg::ZeroByte, win_ff[fmfr_pkg::WinDepth-1:1]};
   assign mshifted  = {fmfr_pkg::ZeroByte, mres.window[fmfr_pkg::WinDepth-1:1]};

   always_comb begin
      state_in    = state_ff;
      win_in      = win_ff;
      fill_in     = fill_ff;
      repl_in     = repl_ff;
      emit        = 1'b0;
      rsp_byte_in = win_ff[0];
      rsp_flag_in = 1'b1;
      rsp_last_in = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if (req_tuser == fmfr_pkg::KindText) begin
                  repl_in = repl_ff | mres.hit;
                  if (mres.fill >= depth) begin
                     // The new byte pushes the oldest one out of the window.
                     emit        = 1'b1;
                     rsp_byte_in = mres.window[0];
                     win_in      = mshifted;
                     fill_in     = mfill_dec;
                     if (mfill_dec >= depth) begin
                        state_in = ST_DRAIN_TEXT;
                     end
                  end else begin
                     win_in  = mres.window;
                     fill_in = mres.fill;
                  end
               end else begin
                  // End of text: the matcher is rearmed and the window drained.
                  repl_in     = 1'b0;
                  emit        = 1'b1;
                  rsp_last_in = (fill_ff <= fmfr_pkg::FillW'(1));
                  if (fill_ff == '0) begin
                     rsp_byte_in = fmfr_pkg::ZeroByte;
                     rsp_flag_in = 1'b0;
                  end else begin
                     win_in  = shifted;
                     fill_in = fill_dec;
                     if (fill_ff > fmfr_pkg::FillW'(1)) begin
                        state_in = ST_DRAIN_FLUSH;
                     end
                  end
               end
            end
         end
         ST_DRAIN_TEXT: begin
            if (out_free) begin
               emit    = 1'b1;
               win_in  = shifted;
               fill_in = fill_dec;
               if (fill_dec < depth) begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_DRAIN_FLUSH: begin
            if (out_free) begin
               emit        = 1'b1;
               rsp_last_in = (fill_ff == fmfr_pkg::FillW'(1));
               win_in      = shifted;
               fill_in     = fill_dec;
               if (fill_ff == fmfr_pkg::FillW'(1)) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      rsp_valid_in = emit ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         repl_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         repl_ff      <= repl_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      win_ff <= win_in;
      if (emit) begin
         rsp_byte_ff <= rsp_byte_in;
         rsp_flag_ff <= rsp_flag_in;
         rsp_last_ff <= rsp_last_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_byte_ff;
   assign rsp_tuser  = rsp_flag_ff;
   assign rsp_tlast  = rsp_last_ff;

`ifndef SYNTH
   // The window never holds more bytes than it has entries.
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= fmfr_pkg::FillW'(fmfr_pkg::WinDepth))
      else $error("window fill beyond depth");

   // A flush drain only runs while bytes remain.
   a_flush_nonempty: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DRAIN_FLUSH |-> fill_ff != '0)
      else $error("flush drain with empty window");

   // Once the last beat of a text is out, the window is empty and the matcher rearmed.
   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_last_ff |-> fill_ff == '0 && !repl_ff)
      else $error("end of text with bytes still held");

   // A beat without a byte can only be the single beat of an empty flush.
   a_empty_flush: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_flag_ff |-> rsp_last_ff && rsp_byte_ff == fmfr_pkg::ZeroByte)
      else $error("byteless beat outside an empty flush");

   // Finishing a text drain leaves fewer bytes than the active depth (the find length, or one).
   a_drain_stop: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DRAIN_TEXT && state_in == ST_IDLE |=> fill_ff < depth)
      else $error("text drain stopped early");
`endif

endmodule
